// ===== src/lpse_pkg.sv =====
// package with request and result types for the link port serial exchange
package lpse_pkg;

  // request kinds carried in the mode field
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_EDGE  = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] send_byte;
    logic       clk_internal;
    logic       serial_in_bit;
  } req_t;

  typedef struct packed {
    logic       serial_out_bit;
    logic       clock_out_level;
    logic       clock_drives_pin;
    logic [7:0] received_byte;
    logic       byte_done;
    logic       busy_res;
  } res_t;

endpackage

// ===== src/lpse_if.sv =====
// valid/ready channel interfaces for requests and results
interface lpse_req_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] send_byte;
  logic       clk_internal;
  logic       serial_in_bit;

  modport source (output valid, mode, send_byte, clk_internal, serial_in_bit,
                  input ready);
  modport sink   (input valid, mode, send_byte, clk_internal, serial_in_bit,
                  output ready);
endinterface

interface lpse_res_if;
  logic       valid;
  logic       ready;
  logic       serial_out_bit;
  logic       clock_out_level;
  logic       clock_drives_pin;
  logic [7:0] received_byte;
  logic       byte_done;
  logic       busy_res;

  modport source (output valid, serial_out_bit, clock_out_level, clock_drives_pin,
                  received_byte, byte_done, busy_res, input ready);
  modport sink   (input valid, serial_out_bit, clock_out_level, clock_drives_pin,
                  received_byte, byte_done, busy_res, output ready);
endinterface

// ===== src/link_port_serial_exchange.sv =====
// top level of the link port serial exchange with request and result registers
//
// usage:
//   req_i carries one request per handshake: mode 0 starts an exchange
//   (send_byte, clk_internal), mode 1 reports one clock edge
//   (a timer half-period or a partner pin edge) with the serial_in_bit level.
//   res_o returns exactly one result per request, in request order, with
//   the line levels, clock drive flag, busy and, on the last bit, the
//   received byte and a byte_done pulse.
// pipeline and throughput:
//   a request is captured in the input register, then the shift logic
//   updates the port state and loads the result register once the result
//   slot is free, and res_o.valid is driven from the result register. one
//   request per cycle is sustained while res_o.ready stays high.
// reset:
//   rst_ni clears the valid bits of both pipeline registers, leaves the port
//   idle, the clock level high and the output line idle high.
// stalls:
//   when res_o.ready is low the result register holds, the input register
//   fills and then req_i.ready drops; nothing is lost or repeated.
module link_port_serial_exchange #(
  parameter int BITS_PER_BYTE = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpse_req_if.sink   req_i,
  lpse_res_if.source res_o
);
  import lpse_pkg::*;

  // input register
  logic req_valid_q;
  req_t req_q;
  // result register
  logic res_valid_q;
  res_t res_q;
  res_t res_next;
  logic advance;

  // request moves into the state logic when the result slot is free
  assign advance     = req_valid_q & (~res_valid_q | res_o.ready);
  assign req_i.ready = ~req_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      req_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      req_q.mode          <= req_i.mode;
      req_q.send_byte     <= req_i.send_byte;
      req_q.clk_internal  <= req_i.clk_internal;
      req_q.serial_in_bit <= req_i.serial_in_bit;
    end
  end

  // port state and the per-request update
  lpse_step #(
    .BITS_PER_BYTE(BITS_PER_BYTE)
  ) u_step (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (advance),
    .req_i (req_q),
    .res_o (res_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign res_o.valid            = res_valid_q;
  assign res_o.serial_out_bit   = res_q.serial_out_bit;
  assign res_o.clock_out_level  = res_q.clock_out_level;
  assign res_o.clock_drives_pin = res_q.clock_drives_pin;
  assign res_o.received_byte    = res_q.received_byte;
  assign res_o.byte_done        = res_q.byte_done;
  assign res_o.busy_res         = res_q.busy_res;

endmodule

// ===== src/lpse_step.sv =====
// shift register state and per-request update of the serial exchange
module lpse_step #(
  parameter int BITS_PER_BYTE = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  lpse_pkg::req_t req_i,
  output lpse_pkg::res_t res_o
);
  import lpse_pkg::*;

  localparam int BLW = $clog2(BITS_PER_BYTE + 1);
  localparam int HPW = $clog2(2 * BITS_PER_BYTE + 1);
  localparam logic [BLW-1:0] BitsInit = BLW'(BITS_PER_BYTE);
  localparam logic [HPW-1:0] TicksInit = HPW'(2 * BITS_PER_BYTE);

  logic [7:0]     out_shift_q, out_shift_d;
  logic [7:0]     in_shift_q, in_shift_d;
  logic [BLW-1:0] bits_left_q, bits_left_d;
  logic           clock_level_q, clock_level_d;
  logic           falling_seen_q, falling_seen_d;
  logic           internal_mode_q, internal_mode_d;
  logic [HPW-1:0] half_periods_q, half_periods_d;
  logic           active_q, active_d;
  logic           out_level_q, out_level_d;
  logic           done;
  logic [7:0]     rx;

  always_comb begin
    out_shift_d     = out_shift_q;
    in_shift_d      = in_shift_q;
    bits_left_d     = bits_left_q;
    clock_level_d   = clock_level_q;
    falling_seen_d  = falling_seen_q;
    internal_mode_d = internal_mode_q;
    half_periods_d  = half_periods_q;
    active_d        = active_q;
    out_level_d     = out_level_q;
    done            = 1'b0;
    rx              = 8'h00;

    if (req_i.mode == MODE_START) begin
      // start aborts any transfer; output line keeps its level
      out_shift_d     = req_i.send_byte;
      in_shift_d      = 8'h00;
      bits_left_d     = BitsInit;
      clock_level_d   = 1'b1;
      falling_seen_d  = 1'b0;
      internal_mode_d = req_i.clk_internal;
      half_periods_d  = req_i.clk_internal ? TicksInit : '0;
      active_d        = 1'b1;
    end else if (active_q) begin
      clock_level_d = ~clock_level_q;
      if (clock_level_d) begin
        // rising edge: sample only after a falling edge
        if (falling_seen_q && (bits_left_q != '0)) begin
          in_shift_d  = {in_shift_q[6:0], req_i.serial_in_bit};
          bits_left_d = bits_left_q - BLW'(1);
          if (bits_left_d == '0) begin
            done     = 1'b1;
            rx       = in_shift_d;
            active_d = 1'b0;
          end
        end
      end else begin
        falling_seen_d = 1'b1;
        if (bits_left_q != '0) begin
          out_level_d = out_shift_q[7];
          out_shift_d = {out_shift_q[6:0], 1'b1};
        end else begin
          out_level_d = 1'b1;
        end
      end
      if (internal_mode_q) begin
        if (half_periods_q != '0) begin
          half_periods_d = half_periods_q - HPW'(1);
        end
        if (half_periods_d == '0) begin
          active_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_shift_q     <= 8'h00;
      in_shift_q      <= 8'h00;
      bits_left_q     <= BitsInit;
      clock_level_q   <= 1'b1;
      falling_seen_q  <= 1'b0;
      internal_mode_q <= 1'b0;
      half_periods_q  <= '0;
      active_q        <= 1'b0;
      out_level_q     <= 1'b1;
    end else if (en_i) begin
      out_shift_q     <= out_shift_d;
      in_shift_q      <= in_shift_d;
      bits_left_q     <= bits_left_d;
      clock_level_q   <= clock_level_d;
      falling_seen_q  <= falling_seen_d;
      internal_mode_q <= internal_mode_d;
      half_periods_q  <= half_periods_d;
      active_q        <= active_d;
      out_level_q     <= out_level_d;
    end
  end

  always_comb begin
    res_o.serial_out_bit   = out_level_d;
    res_o.clock_out_level  = clock_level_d;
    res_o.clock_drives_pin = active_d & internal_mode_d;
    res_o.received_byte    = rx;
    res_o.byte_done        = done;
    res_o.busy_res         = active_d;
  end

endmodule

// ===== bench/lpse_exchange_checker.sv =====
// checker that predicts and compares link port serial exchange results
`timescale 1ns / 100ps

module lpse_exchange_checker
  import lpse_pkg::*;
#(
  parameter int BITS_PER_BYTE = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  lpse_req_if  req_i,
  lpse_res_if  res_i,
  output int   mismatch_cnt_o,
  output int   pending_o
);

  // predicted port state
  logic [7:0] tx_shift;
  logic [7:0] rx_shift;
  logic [4:0] bits_to_go;
  logic       clk_level;
  logic       fall_seen;
  logic       int_clk;
  logic [5:0] ticks_left;
  logic       busy;
  logic       line_level;

  res_t line_results_q[$];

  function automatic res_t predict_exchange(req_t r);
    res_t o;
    o = '0;
    if (r.mode == MODE_START) begin
      tx_shift   = r.send_byte;
      rx_shift   = '0;
      bits_to_go = 5'(BITS_PER_BYTE);
      clk_level  = 1'b1;
      fall_seen  = 1'b0;
      int_clk    = r.clk_internal;
      ticks_left = r.clk_internal ? 6'(2 * BITS_PER_BYTE) : 6'd0;
      busy       = 1'b1;
    end else if (busy) begin
      clk_level = ~clk_level;
      if (clk_level) begin
        // rising edge samples only after a falling edge
        if (fall_seen && bits_to_go != 0) begin
          rx_shift   = {rx_shift[6:0], r.serial_in_bit};
          bits_to_go = bits_to_go - 5'd1;
          if (bits_to_go == 0) begin
            o.byte_done     = 1'b1;
            o.received_byte = rx_shift;
            busy            = 1'b0;
          end
        end
      end else begin
        fall_seen = 1'b1;
        if (bits_to_go != 0) begin
          line_level = tx_shift[7];
          tx_shift   = {tx_shift[6:0], 1'b1};
        end else begin
          line_level = 1'b1;
        end
      end
      if (int_clk) begin
        if (ticks_left != 0) ticks_left = ticks_left - 6'd1;
        if (ticks_left == 0) busy = 1'b0;
      end
    end
    o.serial_out_bit   = line_level;
    o.clock_out_level  = clk_level;
    o.clock_drives_pin = busy & int_clk;
    o.busy_res         = busy;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    req_t req;
    res_t got;
    res_t want;
    if (!rst_ni) begin
      tx_shift       = '0;
      rx_shift       = '0;
      bits_to_go     = 5'(BITS_PER_BYTE);
      clk_level      = 1'b1;
      fall_seen      = 1'b0;
      int_clk        = 1'b0;
      ticks_left     = '0;
      busy           = 1'b0;
      line_level     = 1'b1;
      line_results_q.delete();
      mismatch_cnt_o = 0;
      pending_o      = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        got = '{res_i.serial_out_bit, res_i.clock_out_level, res_i.clock_drives_pin,
                res_i.received_byte, res_i.byte_done, res_i.busy_res};
        if (line_results_q.size() == 0) begin
          mismatch_cnt_o++;
          if (mismatch_cnt_o <= 10)
            $display("%0t: result with no request outstanding: %p", $time, got);
        end else begin
          want = line_results_q.pop_front();
          if (got.serial_out_bit !== want.serial_out_bit ||
              got.clock_out_level !== want.clock_out_level ||
              got.clock_drives_pin !== want.clock_drives_pin ||
              got.received_byte !== want.received_byte ||
              got.byte_done !== want.byte_done ||
              got.busy_res !== want.busy_res) begin
            mismatch_cnt_o++;
            if (mismatch_cnt_o <= 10)
              $display({"%0t: result error exp so=%b clk=%b drv=%b rx=%h done=%b busy=%b,",
                        " got so=%b clk=%b drv=%b rx=%h done=%b busy=%b"},
                       $time, want.serial_out_bit, want.clock_out_level,
                       want.clock_drives_pin, want.received_byte, want.byte_done,
                       want.busy_res, got.serial_out_bit, got.clock_out_level,
                       got.clock_drives_pin, got.received_byte, got.byte_done,
                       got.busy_res);
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        req = '{req_i.mode, req_i.send_byte, req_i.clk_internal, req_i.serial_in_bit};
        line_results_q.push_back(predict_exchange(req));
      end
      pending_o = line_results_q.size();
    end
  end

endmodule

// ===== bench/tb_link_port_serial_exchange.sv =====
// testbench top for the link port serial exchange: stimulus, stalls and verdict
`timescale 1ns / 100ps

module tb_link_port_serial_exchange;
  import lpse_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lpse_req_if req_ch ();
  lpse_res_if res_ch ();

  int mismatch_cnt;
  int pending;

  // idle rates of both sides in percent, changed per phase
  int send_idle_pct = 27;
  int recv_idle_pct = 61;
  // set by the request side to make the receiver hold off for a long stretch
  bit hold_req = 1'b0;
  // requests sent by run_exchange (stray edges outside it not counted)
  int live_reqs = 0;

  always #2 clk_i = ~clk_i;

  link_port_serial_exchange dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .res_o  (res_ch)
  );

  lpse_exchange_checker chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_ch),
    .res_i          (res_ch),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending)
  );

  // offer one request, with random gaps before it, and wait until it is taken
  // valid stays high into the next request when no gap is drawn
  task automatic send_req(input logic mode, input logic [7:0] tx, input logic ic,
                          input logic sin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid         <= 1'b1;
    req_ch.mode          <= mode;
    req_ch.send_byte     <= tx;
    req_ch.clk_internal  <= ic;
    req_ch.serial_in_bit <= sin;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
  endtask

  // clock edge request: unused fields carry random noise
  task automatic send_edge(input bit counted);
    send_req(MODE_EDGE, 8'($urandom), 1'($urandom), 1'($urandom));
    if (counted) live_reqs++;
  endtask

  // one start request followed by a run of clock edges
  // a full byte's worth of edges completes a byte, fewer leave it for the next start to abort,
  // more add edges that land on an idle port
  task automatic run_exchange(input logic [7:0] tx, input logic ic, input int n_edges);
    send_req(MODE_START, tx, ic, 1'($urandom));
    live_reqs++;
    repeat (n_edges) send_edge(1'b1);
  endtask

  // receiver: random ready, plus one long hold-off on request
  initial begin
    res_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (60) @(posedge clk_i);
        hold_req = 1'b0;
      end
      res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    logic [7:0] tx;
    int         pick;
    req_ch.valid         <= 1'b0;
    req_ch.mode          <= MODE_START;
    req_ch.send_byte     <= '0;
    req_ch.clk_internal  <= 1'b0;
    req_ch.serial_in_bit <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: edge on an idle port, aborted internal-clock byte,
    // then a full external-clock byte of all ones
    send_edge(1'b0);
    run_exchange(8'hA5, 1'b1, 5);
    run_exchange(8'hFF, 1'b0, 16);

    // random exchanges, mostly complete bytes
    while (live_reqs < 1700) begin
      // phase by progress: receiver idles more first, then sender, then neither
      if (live_reqs < 570) begin
        send_idle_pct = 27;
        recv_idle_pct = 61;
      end else if (live_reqs < 1140) begin
        send_idle_pct = 61;
        recv_idle_pct = 27;
      end else begin
        if (send_idle_pct != 0) hold_req = 1'b1;
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        // corner bytes for the shift path
        case ($urandom_range(0, 3))
          0: tx = 8'h00;
          1: tx = 8'hFF;
          2: tx = 8'h80;
          default: tx = 8'h7F;
        endcase
      end else begin
        tx = 8'($urandom);
      end

      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 3)) send_edge(1'b0);
      end else if (pick < 18) begin
        run_exchange(tx, 1'($urandom), $urandom_range(1, 15));
      end else if (pick < 26) begin
        run_exchange(tx, 1'($urandom), 16 + $urandom_range(1, 4));
      end else begin
        run_exchange(tx, 1'($urandom), 16);
      end
    end
    req_ch.valid <= 1'b0;

    // drain: every predicted result must come back
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatch_cnt == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
